// ===== rtl/core/ppg_pkg.sv =====
// ----------------------------------------------------------------------------
// ppg_pkg: shared types and constants of the presence and posture guard
// Holds the item, result, configuration and state records, the command
// codes, the event bit positions and the register map.
// ----------------------------------------------------------------------------
package ppg_pkg;

  // Width of a timestamp in milliseconds.
  localparam int unsigned TIME_W = 48;

  // Stream and register port widths.
  localparam int unsigned S_DATA_W   = 64;
  localparam int unsigned M_DATA_W   = 24;
  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned REG_IDX_W  = 3;

  // Register reset values.
  localparam logic [31:0] SIT_LIMIT_RST     = 32'd1800000;
  localparam logic [31:0] ACK_GRACE_RST     = 32'd60000;
  localparam logic [31:0] BREAK_CONFIRM_RST = 32'd300000;
  localparam logic [31:0] PRIV_LEAVE_RST    = 32'd15000;
  localparam logic [31:0] POSTURE_HOLD_RST  = 32'd10000;
  localparam logic [7:0]  POSTURE_LIMIT_RST = 8'd70;

  // Event mask bit positions.
  localparam int unsigned EV_PRESENCE    = 0;
  localparam int unsigned EV_BREAK       = 1;
  localparam int unsigned EV_SIT         = 2;
  localparam int unsigned EV_POSTURE     = 3;
  localparam int unsigned EV_PRIVACY_ON  = 4;
  localparam int unsigned EV_PRIVACY_OFF = 5;
  localparam int unsigned EV_BLUR        = 6;
  localparam int unsigned EV_UNBLUR      = 7;
  localparam int unsigned EV_LOCK        = 8;
  localparam int unsigned EV_PAUSE       = 9;
  localparam int unsigned EV_ACTIVE      = 10;
  localparam int unsigned EV_ACK         = 11;
  localparam int unsigned EV_BRIGHT_UP   = 12;
  localparam int unsigned EV_BRIGHT_DOWN = 13;
  localparam int unsigned EV_W           = 14;

  typedef enum logic [2:0] {
    CMD_NONE        = 3'd0,
    CMD_ACK         = 3'd1,
    CMD_PAUSE       = 3'd2,
    CMD_RESUME      = 3'd3,
    CMD_PRIVACY_ON  = 3'd4,
    CMD_PRIVACY_OFF = 3'd5,
    CMD_BRIGHT_UP   = 3'd6,
    CMD_BRIGHT_DOWN = 3'd7
  } ppg_cmd_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SIT_LIMIT     = 3'd0,
    REG_ACK_GRACE     = 3'd1,
    REG_BREAK_CONFIRM = 3'd2,
    REG_PRIV_LEAVE    = 3'd3,
    REG_POSTURE_HOLD  = 3'd4,
    REG_POSTURE_LIMIT = 3'd5,
    REG_LOCK_UNANS    = 3'd6,
    REG_LOCK_PRIV     = 3'd7
  } ppg_reg_e;

  // Input word; the first field sits in the highest bits.
  typedef struct packed {
    ppg_cmd_e          command;
    logic [7:0]        slouch_score;
    logic              vision_ok;
    logic [3:0]        faces;
    logic [TIME_W-1:0] now_ms;
  } ppg_item_t;

  // Result word; the first field sits in the highest bits.
  typedef struct packed {
    logic            reminders_off;
    logic            privacy_active;
    logic            is_present;
    logic [EV_W-1:0] events;
  } ppg_result_t;

  typedef struct packed {
    logic [31:0] sit_limit_ms;
    logic [31:0] ack_grace_ms;
    logic [31:0] away_confirm_ms;
    logic [31:0] privacy_leave_lock_ms;
    logic [31:0] slouch_hold_ms;
    logic [7:0]  posture_limit;
    logic        lock_on_unanswered;
    logic        lock_on_privacy_leave;
  } ppg_cfg_t;

  typedef struct packed {
    logic              started;
    logic              present_flag;
    logic [TIME_W-1:0] present_since;
    logic [TIME_W-1:0] absent_since;
    logic [TIME_W-1:0] bad_posture_since;
    logic              posture_alert_done;
    logic              sit_alert_done;
    logic              waiting_ack;
    logic [TIME_W-1:0] waiting_ack_since;
    logic              lock_done;
    logic              paused_flag;
    logic              privacy_flag;
    logic              blurred_flag;
    logic              vision_frozen;
    logic [TIME_W-1:0] frozen_since;
    logic              pending_ack_restart;
  } ppg_state_t;

endpackage

// ===== rtl/core/presence_posture_guard_fsm.sv =====
// ----------------------------------------------------------------------------
// presence_posture_guard_fsm: presence, posture and privacy guard
// Turns a stream of vision observations into event masks and status flags.
// ----------------------------------------------------------------------------
// Usage:
// Observations arrive on the slave stream, one word per observation, and each
// produces exactly one result word on the master stream, in order.
// An accepted word is held in an input register. In the next cycle the step
// logic evaluates it against the guard state and, if the result register is
// free or being drained, commits the new state and loads the result. One word
// per cycle is sustained while the receiver takes every result; the path that
// sets this is the combinational step logic from the input register through
// the timer compares into the state register.
// When the receiver stalls, the result register holds its word, the input
// register fills, and s_axis_tready drops only when both are occupied.
// Reset clears both stages, the guard state and all timers (zero means unset),
// and loads the register defaults. Registers sit on the peripheral bus at
// byte addresses 0x00 through 0x1C and are to be written only while the stream
// is idle; the user must keep to this, as the block does not enforce it.
// ----------------------------------------------------------------------------
module presence_posture_guard_fsm (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration port.
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ppg_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [ppg_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [ppg_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready,
  // Observation stream.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // From bit 0: now_ms[47:0], faces[51:48], vision_ok[52],
  // slouch_score[60:53], command[63:61].
  input  logic [ppg_pkg::S_DATA_W-1:0]        s_axis_tdata,
  // Result stream.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // From bit 0: events[13:0], is_present[14], privacy_active[15],
  // reminders_off[16], zero fill [23:17].
  output logic [ppg_pkg::M_DATA_W-1:0]        m_axis_tdata
);

  ppg_pkg::ppg_cfg_t    cfg;
  ppg_pkg::ppg_item_t   in_q;
  logic                 in_valid_q;
  ppg_pkg::ppg_state_t  state_q;
  ppg_pkg::ppg_state_t  state_d;
  ppg_pkg::ppg_result_t res_d;
  ppg_pkg::ppg_result_t out_q;
  logic                 out_valid_q;
  logic                 out_free;
  logic                 advance;

  ppg_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ppg_step u_step (
    .item_i   (in_q),
    .state_i  (state_q),
    .cfg_i    (cfg),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // The result register can take a word when empty or being read this cycle.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || advance;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(ppg_pkg::M_DATA_W - $bits(ppg_pkg::ppg_result_t))'(0), out_q};

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q <= ppg_pkg::ppg_item_t'(s_axis_tdata);
    end
  end

  // Guard state commits only when the evaluated word moves to the output.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      state_q     <= state_d;
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res_d;
    end
  end

  // A word that leaves the input register always lands in the result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> m_axis_tvalid)
    else $error("evaluated word did not reach the result register");

  // Back-pressure only when both stages hold a word and the receiver stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled while a stage was free");

  // The screen is blurred only while privacy mode is on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.blurred_flag |-> state_q.privacy_flag)
    else $error("blur held outside privacy mode");

  // The freeze mark is set only while vision is frozen.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !state_q.vision_frozen |-> (state_q.frozen_since == '0))
    else $error("freeze mark left set after resume");

endmodule

// ===== rtl/core/ppg_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// ppg_cfg_regs: register file of the presence and posture guard
// Eight registers at word addresses behind a simple peripheral bus port.
// ----------------------------------------------------------------------------
module ppg_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ppg_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [ppg_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [ppg_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready,
  output ppg_pkg::ppg_cfg_t                 cfg_o
);

  ppg_pkg::ppg_cfg_t cfg_q;
  ppg_pkg::ppg_reg_e reg_idx;
  logic              wr_en;

  assign reg_idx = ppg_pkg::ppg_reg_e'(paddr[ppg_pkg::APB_ADDR_W-1:2]);
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sit_limit_ms          <= ppg_pkg::SIT_LIMIT_RST;
      cfg_q.ack_grace_ms          <= ppg_pkg::ACK_GRACE_RST;
      cfg_q.away_confirm_ms       <= ppg_pkg::BREAK_CONFIRM_RST;
      cfg_q.privacy_leave_lock_ms <= ppg_pkg::PRIV_LEAVE_RST;
      cfg_q.slouch_hold_ms        <= ppg_pkg::POSTURE_HOLD_RST;
      cfg_q.posture_limit         <= ppg_pkg::POSTURE_LIMIT_RST;
      cfg_q.lock_on_unanswered    <= 1'b1;
      cfg_q.lock_on_privacy_leave <= 1'b1;
    end else if (wr_en) begin
      case (reg_idx)
        ppg_pkg::REG_SIT_LIMIT:     cfg_q.sit_limit_ms          <= pwdata;
        ppg_pkg::REG_ACK_GRACE:     cfg_q.ack_grace_ms          <= pwdata;
        ppg_pkg::REG_BREAK_CONFIRM: cfg_q.away_confirm_ms       <= pwdata;
        ppg_pkg::REG_PRIV_LEAVE:    cfg_q.privacy_leave_lock_ms <= pwdata;
        ppg_pkg::REG_POSTURE_HOLD:  cfg_q.slouch_hold_ms        <= pwdata;
        ppg_pkg::REG_POSTURE_LIMIT: cfg_q.posture_limit         <= pwdata[7:0];
        ppg_pkg::REG_LOCK_UNANS:    cfg_q.lock_on_unanswered    <= pwdata[0];
        ppg_pkg::REG_LOCK_PRIV:     cfg_q.lock_on_privacy_leave <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      ppg_pkg::REG_SIT_LIMIT:     prdata = cfg_q.sit_limit_ms;
      ppg_pkg::REG_ACK_GRACE:     prdata = cfg_q.ack_grace_ms;
      ppg_pkg::REG_BREAK_CONFIRM: prdata = cfg_q.away_confirm_ms;
      ppg_pkg::REG_PRIV_LEAVE:    prdata = cfg_q.privacy_leave_lock_ms;
      ppg_pkg::REG_POSTURE_HOLD:  prdata = cfg_q.slouch_hold_ms;
      ppg_pkg::REG_POSTURE_LIMIT: prdata = {24'd0, cfg_q.posture_limit};
      ppg_pkg::REG_LOCK_UNANS:    prdata = {31'd0, cfg_q.lock_on_unanswered};
      ppg_pkg::REG_LOCK_PRIV:     prdata = {31'd0, cfg_q.lock_on_privacy_leave};
      default:                    prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/ppg_step.sv =====
// ----------------------------------------------------------------------------
// ppg_step: next-state and event logic for one observation
// Applies the command, the vision freeze and resume shift, the presence,
// posture, sedentary, blur and lock rules, in that order.
// ----------------------------------------------------------------------------
module ppg_step (
  input  ppg_pkg::ppg_item_t   item_i,
  input  ppg_pkg::ppg_state_t  state_i,
  input  ppg_pkg::ppg_cfg_t    cfg_i,
  output ppg_pkg::ppg_state_t  state_o,
  output ppg_pkg::ppg_result_t result_o
);

  // True once span has elapsed since the mark; false if time went backwards.
  function automatic logic passed(input logic [ppg_pkg::TIME_W-1:0] now,
                                  input logic [ppg_pkg::TIME_W-1:0] since,
                                  input logic [31:0]                span);
    logic [ppg_pkg::TIME_W-1:0] diff;
    diff = now - since;
    return (now >= since) && (diff >= ppg_pkg::TIME_W'(span));
  endfunction

  // Shift a set mark forward, saturating at the all-ones time.
  function automatic logic [ppg_pkg::TIME_W-1:0] push_fwd(
      input logic [ppg_pkg::TIME_W-1:0] ts,
      input logic [ppg_pkg::TIME_W-1:0] span);
    logic [ppg_pkg::TIME_W:0] sum;
    sum = {1'b0, ts} + {1'b0, span};
    if (ts == '0) begin
      return ts;
    end else if (sum[ppg_pkg::TIME_W]) begin
      return '1;
    end else begin
      return sum[ppg_pkg::TIME_W-1:0];
    end
  endfunction

  ppg_pkg::ppg_state_t        s;
  logic [ppg_pkg::EV_W-1:0]   ev;
  logic [ppg_pkg::TIME_W-1:0] now;
  logic [ppg_pkg::TIME_W-1:0] span;
  logic                       face;
  logic                       is_ack;

  always_comb begin
    s      = state_i;
    ev     = '0;
    now    = item_i.now_ms;
    face   = (item_i.faces != 4'd0);
    is_ack = (item_i.command == ppg_pkg::CMD_ACK);
    span   = '0;

    case (item_i.command)
      ppg_pkg::CMD_ACK: begin
        s.waiting_ack    = 1'b0;
        s.sit_alert_done = 1'b0;
        s.lock_done      = 1'b0;
        ev[ppg_pkg::EV_ACK] = 1'b1;
      end
      ppg_pkg::CMD_PAUSE: begin
        if (!s.paused_flag) begin
          s.paused_flag = 1'b1;
          ev[ppg_pkg::EV_PAUSE] = 1'b1;
        end
      end
      ppg_pkg::CMD_RESUME: begin
        if (s.paused_flag) begin
          s.paused_flag = 1'b0;
          ev[ppg_pkg::EV_ACTIVE] = 1'b1;
        end
      end
      ppg_pkg::CMD_PRIVACY_ON: begin
        if (!s.privacy_flag) begin
          s.privacy_flag = 1'b1;
          ev[ppg_pkg::EV_PRIVACY_ON] = 1'b1;
        end
      end
      ppg_pkg::CMD_PRIVACY_OFF: begin
        if (s.privacy_flag) begin
          s.privacy_flag = 1'b0;
          ev[ppg_pkg::EV_PRIVACY_OFF] = 1'b1;
          if (s.blurred_flag) begin
            s.blurred_flag = 1'b0;
            ev[ppg_pkg::EV_UNBLUR] = 1'b1;
          end
        end
      end
      ppg_pkg::CMD_BRIGHT_UP:   ev[ppg_pkg::EV_BRIGHT_UP]   = 1'b1;
      ppg_pkg::CMD_BRIGHT_DOWN: ev[ppg_pkg::EV_BRIGHT_DOWN] = 1'b1;
      default: ;
    endcase

    if (!item_i.vision_ok) begin
      // Timers hold; only the freeze start and a pending restart are noted.
      if (!s.vision_frozen) begin
        s.vision_frozen = 1'b1;
        s.frozen_since  = now;
      end
      if (is_ack && s.present_flag) begin
        s.pending_ack_restart = 1'b1;
      end
    end else begin
      if (s.vision_frozen) begin
        span = (now >= s.frozen_since) ? (now - s.frozen_since) : '0;
        s.present_since     = push_fwd(s.present_since, span);
        s.absent_since      = push_fwd(s.absent_since, span);
        s.bad_posture_since = push_fwd(s.bad_posture_since, span);
        s.waiting_ack_since = push_fwd(s.waiting_ack_since, span);
        s.vision_frozen     = 1'b0;
        s.frozen_since      = '0;
      end
      if (s.pending_ack_restart) begin
        s.present_since       = now;
        s.pending_ack_restart = 1'b0;
      end
      if (is_ack && face) begin
        s.present_since = now;
      end
      if (!s.started) begin
        s.started      = 1'b1;
        s.present_flag = face;
        if (face) begin
          s.present_since = now;
          ev[ppg_pkg::EV_PRESENCE] = 1'b1;
        end else begin
          s.absent_since = now;
        end
      end

      if (face) begin
        if (!s.present_flag) begin
          s.present_flag       = 1'b1;
          s.present_since      = now;
          s.sit_alert_done     = 1'b0;
          s.posture_alert_done = 1'b0;
          s.waiting_ack        = 1'b0;
          s.lock_done          = 1'b0;
          ev[ppg_pkg::EV_PRESENCE] = 1'b1;
        end
        s.absent_since = '0;
        if (item_i.slouch_score >= cfg_i.posture_limit) begin
          if (s.bad_posture_since == '0) begin
            s.bad_posture_since = now;
          end else if (!s.posture_alert_done && !s.paused_flag &&
                       passed(now, s.bad_posture_since, cfg_i.slouch_hold_ms)) begin
            s.posture_alert_done = 1'b1;
            ev[ppg_pkg::EV_POSTURE] = 1'b1;
          end
        end else begin
          s.bad_posture_since  = '0;
          s.posture_alert_done = 1'b0;
        end
        if (!s.paused_flag && !s.sit_alert_done &&
            passed(now, s.present_since, cfg_i.sit_limit_ms)) begin
          s.sit_alert_done    = 1'b1;
          s.waiting_ack       = 1'b1;
          s.waiting_ack_since = now;
          ev[ppg_pkg::EV_SIT] = 1'b1;
        end
      end else if (s.present_flag) begin
        if (s.absent_since == '0) begin
          s.absent_since = now;
        end
        if (passed(now, s.absent_since, cfg_i.away_confirm_ms)) begin
          s.present_flag       = 1'b0;
          s.present_since      = '0;
          s.bad_posture_since  = '0;
          s.sit_alert_done     = 1'b0;
          s.posture_alert_done = 1'b0;
          s.waiting_ack        = 1'b0;
          s.lock_done          = 1'b0;
          ev[ppg_pkg::EV_BREAK] = 1'b1;
        end
      end

      if (s.privacy_flag && (item_i.faces > 4'd1)) begin
        if (!s.blurred_flag) begin
          s.blurred_flag = 1'b1;
          ev[ppg_pkg::EV_BLUR] = 1'b1;
        end
      end else if (s.blurred_flag) begin
        s.blurred_flag = 1'b0;
        ev[ppg_pkg::EV_UNBLUR] = 1'b1;
      end

      if (!s.lock_done && cfg_i.lock_on_unanswered && s.waiting_ack &&
          passed(now, s.waiting_ack_since, cfg_i.ack_grace_ms)) begin
        s.lock_done   = 1'b1;
        s.waiting_ack = 1'b0;
        ev[ppg_pkg::EV_LOCK] = 1'b1;
      end
      if (!s.lock_done && cfg_i.lock_on_privacy_leave && s.privacy_flag && !face &&
          (s.absent_since != '0) &&
          passed(now, s.absent_since, cfg_i.privacy_leave_lock_ms)) begin
        s.lock_done = 1'b1;
        ev[ppg_pkg::EV_LOCK] = 1'b1;
      end
    end

    state_o                 = s;
    result_o.events         = ev;
    result_o.is_present     = s.present_flag;
    result_o.privacy_active = s.privacy_flag;
    result_o.reminders_off  = s.paused_flag;
  end

endmodule

// ===== tb/sv/tb_presence_posture_guard_fsm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_presence_posture_guard_fsm: self-checking bench for the posture guard
// Streams vision observations into the guard and checks every result word.
// A behavioral copy of the guard predicts each result. The run has a short
// hand-written sequence and then random sessions of sitting and absence
// under several timer settings, including all-zero and all-ones limits.
// Random idle gaps and receiver stalls are applied on both streams.
// ----------------------------------------------------------------------------
module tb_presence_posture_guard_fsm;

  localparam logic [ppg_pkg::TIME_W-1:0] TS_TOP       = '1;
  localparam int unsigned                WATCHDOG_MAX = 4000;
  // The receiver holds off once for this long, so both stages of the block
  // fill up and the input stream backs up.
  localparam int unsigned                LONG_HOLD    = 150;
  localparam int unsigned                LONG_HOLD_AT = 120;

  // Every input starts at a known value; the drivers take over from here.
  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic                           psel          = 1'b0;
  logic                           penable       = 1'b0;
  logic                           pwrite        = 1'b0;
  logic [ppg_pkg::APB_ADDR_W-1:0] paddr         = '0;
  logic [ppg_pkg::APB_DATA_W-1:0] pwdata        = '0;
  logic [ppg_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  // From bit 0: now_ms, faces, vision_ok, slouch_score, command.
  logic [ppg_pkg::S_DATA_W-1:0]   s_axis_tdata  = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  // From bit 0: events, is_present, privacy_active, reminders_off, zero fill.
  logic [ppg_pkg::M_DATA_W-1:0]   m_axis_tdata;

  presence_posture_guard_fsm dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Observations waiting to be sent, and the guard results owed by the block
  // for observations it has already taken, oldest first.
  ppg_pkg::ppg_item_t   obs_backlog[$];
  ppg_pkg::ppg_result_t due_results[$];

  int unsigned mismatches = 0;
  int unsigned rx_words   = 0;

  // Timer limits as the bench believes the block holds them.
  logic [31:0] lim_sit, lim_ack, lim_break, lim_priv, lim_hold;
  logic [7:0]  lim_posture;
  logic        lim_lock_unans, lim_lock_priv;

  // Guard state as the bench tracks it. A timestamp of zero means unset.
  logic                       g_started, g_present, g_posture_done, g_sit_done;
  logic                       g_wait_ack, g_locked, g_paused, g_privacy, g_blurred;
  logic                       g_frozen, g_ack_restart;
  logic [ppg_pkg::TIME_W-1:0] g_present_at, g_absent_at, g_bad_at, g_ack_at;
  logic [ppg_pkg::TIME_W-1:0] g_frozen_at;

  // ---------------------------------------------------------------------------
  // Guard prediction
  // ---------------------------------------------------------------------------

  // True once at least span ms lie between mark and t; a clock that has gone
  // backwards never counts as elapsed.
  function automatic bit elapsed(logic [ppg_pkg::TIME_W-1:0] t,
                                 logic [ppg_pkg::TIME_W-1:0] mark,
                                 logic [31:0] span);
    return (t >= mark) && ((t - mark) >= {{(ppg_pkg::TIME_W-32){1'b0}}, span});
  endfunction

  // Moves a set timer mark forward by the time vision was frozen, pinned at
  // the top of the time range instead of wrapping.
  function automatic logic [ppg_pkg::TIME_W-1:0] thaw_mark(
      logic [ppg_pkg::TIME_W-1:0] mark, logic [ppg_pkg::TIME_W-1:0] span);
    if (mark == '0) return mark;
    if (span > TS_TOP - mark) return TS_TOP;
    return mark + span;
  endfunction

  // Applies one observation to the tracked guard state and returns the result
  // word that the block must produce for it.
  function automatic ppg_pkg::ppg_result_t predict_guard(ppg_pkg::ppg_item_t obs);
    logic [ppg_pkg::EV_W-1:0]   ev;
    logic [ppg_pkg::TIME_W-1:0] t;
    logic [ppg_pkg::TIME_W-1:0] span;
    logic                       face;
    ppg_pkg::ppg_result_t       res;
    t    = obs.now_ms;
    face = (obs.faces != 4'd0);
    ev   = '0;

    // Commands act even while vision is invalid.
    case (obs.command)
      ppg_pkg::CMD_ACK: begin
        g_wait_ack = 1'b0;
        g_sit_done = 1'b0;
        g_locked   = 1'b0;
        ev[ppg_pkg::EV_ACK] = 1'b1;
      end
      ppg_pkg::CMD_PAUSE: if (!g_paused) begin
        g_paused     = 1'b1;
        ev[ppg_pkg::EV_PAUSE] = 1'b1;
      end
      ppg_pkg::CMD_RESUME: if (g_paused) begin
        g_paused      = 1'b0;
        ev[ppg_pkg::EV_ACTIVE] = 1'b1;
      end
      ppg_pkg::CMD_PRIVACY_ON: if (!g_privacy) begin
        g_privacy         = 1'b1;
        ev[ppg_pkg::EV_PRIVACY_ON] = 1'b1;
      end
      ppg_pkg::CMD_PRIVACY_OFF: if (g_privacy) begin
        g_privacy          = 1'b0;
        ev[ppg_pkg::EV_PRIVACY_OFF] = 1'b1;
        if (g_blurred) begin
          g_blurred     = 1'b0;
          ev[ppg_pkg::EV_UNBLUR] = 1'b1;
        end
      end
      ppg_pkg::CMD_BRIGHT_UP:   ev[ppg_pkg::EV_BRIGHT_UP]   = 1'b1;
      ppg_pkg::CMD_BRIGHT_DOWN: ev[ppg_pkg::EV_BRIGHT_DOWN] = 1'b1;
      default: ;
    endcase

    if (!obs.vision_ok) begin
      // Timers stop; an ack while present restarts the sitting interval once
      // vision comes back.
      if (!g_frozen) begin
        g_frozen    = 1'b1;
        g_frozen_at = t;
      end
      if (obs.command == ppg_pkg::CMD_ACK && g_present) g_ack_restart = 1'b1;
    end else begin
      if (g_frozen) begin
        span         = (t >= g_frozen_at) ? t - g_frozen_at : '0;
        g_present_at = thaw_mark(g_present_at, span);
        g_absent_at  = thaw_mark(g_absent_at, span);
        g_bad_at     = thaw_mark(g_bad_at, span);
        g_ack_at     = thaw_mark(g_ack_at, span);
        g_frozen     = 1'b0;
        g_frozen_at  = '0;
      end
      if (g_ack_restart) begin
        g_present_at  = t;
        g_ack_restart = 1'b0;
      end
      if (obs.command == ppg_pkg::CMD_ACK && face) g_present_at = t;

      // The first valid observation decides the starting presence.
      if (!g_started) begin
        g_started = 1'b1;
        g_present = face;
        if (face) begin
          g_present_at    = t;
          ev[ppg_pkg::EV_PRESENCE] = 1'b1;
        end else begin
          g_absent_at = t;
        end
      end

      if (face) begin
        if (!g_present) begin
          g_present       = 1'b1;
          g_present_at    = t;
          g_sit_done      = 1'b0;
          g_posture_done  = 1'b0;
          g_wait_ack      = 1'b0;
          g_locked        = 1'b0;
          ev[ppg_pkg::EV_PRESENCE] = 1'b1;
        end
        g_absent_at = '0;
        if (obs.slouch_score >= lim_posture) begin
          if (g_bad_at == '0) begin
            g_bad_at = t;
          end else if (!g_posture_done && !g_paused && elapsed(t, g_bad_at, lim_hold)) begin
            g_posture_done = 1'b1;
            ev[ppg_pkg::EV_POSTURE] = 1'b1;
          end
        end else begin
          g_bad_at       = '0;
          g_posture_done = 1'b0;
        end
        if (!g_paused && !g_sit_done && elapsed(t, g_present_at, lim_sit)) begin
          g_sit_done = 1'b1;
          g_wait_ack = 1'b1;
          g_ack_at   = t;
          ev[ppg_pkg::EV_SIT] = 1'b1;
        end
      end else if (g_present) begin
        if (g_absent_at == '0) g_absent_at = t;
        if (elapsed(t, g_absent_at, lim_break)) begin
          g_present      = 1'b0;
          g_present_at   = '0;
          g_bad_at       = '0;
          g_sit_done     = 1'b0;
          g_posture_done = 1'b0;
          g_wait_ack     = 1'b0;
          g_locked       = 1'b0;
          ev[ppg_pkg::EV_BREAK] = 1'b1;
        end
      end

      // Blur while privacy is on and more than one face looks at the screen.
      if (g_privacy && obs.faces > 4'd1) begin
        if (!g_blurred) begin
          g_blurred   = 1'b1;
          ev[ppg_pkg::EV_BLUR] = 1'b1;
        end
      end else if (g_blurred) begin
        g_blurred     = 1'b0;
        ev[ppg_pkg::EV_UNBLUR] = 1'b1;
      end

      if (!g_locked && lim_lock_unans && g_wait_ack && elapsed(t, g_ack_at, lim_ack)) begin
        g_locked    = 1'b1;
        g_wait_ack  = 1'b0;
        ev[ppg_pkg::EV_LOCK] = 1'b1;
      end
      if (!g_locked && lim_lock_priv && g_privacy && !face && g_absent_at != '0 &&
          elapsed(t, g_absent_at, lim_priv)) begin
        g_locked    = 1'b1;
        ev[ppg_pkg::EV_LOCK] = 1'b1;
      end
    end

    res.events         = ev;
    res.is_present     = g_present;
    res.privacy_active = g_privacy;
    res.reminders_off  = g_paused;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Idle gaps, shared by both stream sides
  // ---------------------------------------------------------------------------

  // Mostly no gap or a short one, now and then a long one.
  function automatic int unsigned draw_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 88) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 45);
  endfunction

  // ---------------------------------------------------------------------------
  // Observation sender: offers the backlog one word at a time, with a random
  // gap after each word. Calm stretches send back to back. The prediction is
  // made at the edge where the block takes the word.
  // ---------------------------------------------------------------------------
  int unsigned tx_gap  = 0;
  int unsigned tx_calm = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        due_results.push_back(predict_guard(ppg_pkg::ppg_item_t'(s_axis_tdata)));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (obs_backlog.size() != 0) begin
          s_axis_tdata  <= obs_backlog.pop_front();
          s_axis_tvalid <= 1'b1;
          if (tx_calm > 0) begin
            tx_calm--;
          end else begin
            tx_gap = draw_gap();
            if ($urandom_range(0, 99) < 3) tx_calm = $urandom_range(15, 50);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: checks each word against the oldest prediction and then
  // stalls for a random number of cycles. Once, the stall is long enough for
  // the block to fill up and hold off the sender.
  // ---------------------------------------------------------------------------
  int unsigned rx_stall = 0;
  int unsigned rx_calm  = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    ppg_pkg::ppg_result_t got, want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[$bits(ppg_pkg::ppg_result_t)-1:0];
        rx_words++;
        if (due_results.size() == 0) begin
          $display("%0t: result word expected none actual %h", $time, m_axis_tdata);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          if (got.events != want.events) begin
            $display("%0t: events expected %h actual %h", $time, want.events, got.events);
            mismatches++;
          end
          if (got.is_present != want.is_present) begin
            $display("%0t: is_present expected %b actual %b",
                     $time, want.is_present, got.is_present);
            mismatches++;
          end
          if (got.privacy_active != want.privacy_active) begin
            $display("%0t: privacy_active expected %b actual %b",
                     $time, want.privacy_active, got.privacy_active);
            mismatches++;
          end
          if (got.reminders_off != want.reminders_off) begin
            $display("%0t: reminders_off expected %b actual %b",
                     $time, want.reminders_off, got.reminders_off);
            mismatches++;
          end
        end
        if (rx_words == LONG_HOLD_AT) begin
          rx_stall = LONG_HOLD;
        end else if (rx_calm > 0) begin
          rx_calm--;
        end else begin
          rx_stall = draw_gap();
          if ($urandom_range(0, 99) < 3) rx_calm = $urandom_range(15, 50);
        end
      end
      if (rx_stall > 0) begin
        rx_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: the run is hung if no word moves on any port for too long.
  // ---------------------------------------------------------------------------
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("%0t: watchdog expired", $time);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Register access
  // ---------------------------------------------------------------------------

  // One write: a setup cycle, then an access cycle that completes at the
  // edge where pready is seen high. The tracked limits follow the write.
  task automatic write_reg(ppg_pkg::ppg_reg_e idx, logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      ppg_pkg::REG_SIT_LIMIT:     lim_sit        = val;
      ppg_pkg::REG_ACK_GRACE:     lim_ack        = val;
      ppg_pkg::REG_BREAK_CONFIRM: lim_break      = val;
      ppg_pkg::REG_PRIV_LEAVE:    lim_priv       = val;
      ppg_pkg::REG_POSTURE_HOLD:  lim_hold       = val;
      ppg_pkg::REG_POSTURE_LIMIT: lim_posture    = val[7:0];
      ppg_pkg::REG_LOCK_UNANS:    lim_lock_unans = val[0];
      ppg_pkg::REG_LOCK_PRIV:     lim_lock_priv  = val[0];
      default: ;
    endcase
  endtask

  task automatic program_limits(logic [31:0] sit, logic [31:0] ack, logic [31:0] brk,
                                logic [31:0] priv, logic [31:0] hold, logic [7:0] plim,
                                logic lock_unans, logic lock_priv);
    write_reg(ppg_pkg::REG_SIT_LIMIT, sit);
    write_reg(ppg_pkg::REG_ACK_GRACE, ack);
    write_reg(ppg_pkg::REG_BREAK_CONFIRM, brk);
    write_reg(ppg_pkg::REG_PRIV_LEAVE, priv);
    write_reg(ppg_pkg::REG_POSTURE_HOLD, hold);
    write_reg(ppg_pkg::REG_POSTURE_LIMIT, {24'd0, plim});
    write_reg(ppg_pkg::REG_LOCK_UNANS, {31'd0, lock_unans});
    write_reg(ppg_pkg::REG_LOCK_PRIV, {31'd0, lock_priv});
  endtask

  // Waits until every queued observation is taken and every result is back,
  // so that the block is idle and the registers may change.
  task automatic drain();
    while (obs_backlog.size() != 0 || s_axis_tvalid || due_results.size() != 0)
      @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  logic [ppg_pkg::TIME_W-1:0] obs_clock = '0;
  int unsigned                run_left  = 0;
  logic                       run_seated;

  task automatic push_obs(logic [ppg_pkg::TIME_W-1:0] t, logic [3:0] faces, logic ok,
                          logic [7:0] score, ppg_pkg::ppg_cmd_e cmd);
    ppg_pkg::ppg_item_t o;
    o.now_ms       = t;
    o.faces        = faces;
    o.vision_ok    = ok;
    o.slouch_score = score;
    o.command      = cmd;
    obs_backlog.push_back(o);
  endtask

  // Random observations grouped into runs of sitting and of absence, so that
  // presence, break, sedentary and lock timers actually expire. The clock
  // mostly creeps forward; now and then it steps back, jumps far ahead or
  // lands near the top of the time range.
  task automatic queue_random(int unsigned n);
    int unsigned       p;
    logic [3:0]        faces;
    logic [7:0]        score;
    ppg_pkg::ppg_cmd_e cmd;
    repeat (n) begin
      if (run_left == 0) begin
        run_left   = $urandom_range(3, 30);
        run_seated = ($urandom_range(0, 99) < 60);
      end
      run_left--;

      p = $urandom_range(0, 99);
      if (p < 88)      obs_clock += ppg_pkg::TIME_W'($urandom_range(0, 12));
      else if (p < 93) obs_clock -= ppg_pkg::TIME_W'($urandom_range(1, 20));
      else if (p < 96) obs_clock += ppg_pkg::TIME_W'($urandom);
      else if (p < 98) obs_clock = TS_TOP - ppg_pkg::TIME_W'($urandom_range(0, 300));
      else             obs_clock = {16'($urandom), $urandom};

      // A seated user now and then drops out of view; an empty desk now and
      // then shows a passing face.
      p = $urandom_range(0, 99);
      if (run_seated) begin
        if (p < 8)       faces = 4'd0;
        else if (p < 80) faces = 4'd1;
        else             faces = 4'($urandom_range(2, 15));
      end else begin
        faces = (p < 90) ? 4'd0 : 4'($urandom_range(1, 15));
      end

      p = $urandom_range(0, 99);
      if (p < 40)      score = 8'($urandom_range(0, 255));
      else if (p < 70) score = 8'($urandom_range(lim_posture, 255));
      else             score = 8'($urandom_range(0, lim_posture));

      cmd = ($urandom_range(0, 99) < 65) ? ppg_pkg::CMD_NONE
                                         : ppg_pkg::ppg_cmd_e'(3'($urandom_range(1, 7)));
      push_obs(obs_clock, faces, ($urandom_range(0, 99) < 92), score, cmd);
    end
  endtask

  // Hand-written opening under short timers: start at time zero, posture and
  // sitting alerts, blur and unblur, an ack during frozen vision, a thaw that
  // saturates at the top of the time range, the clock running backwards, a
  // privacy lock, a break and every command.
  task automatic queue_directed();
    push_obs(48'd0,   4'd1,  1'b1, 8'd0,   ppg_pkg::CMD_NONE);
    push_obs(48'd5,   4'd1,  1'b1, 8'd255, ppg_pkg::CMD_PRIVACY_ON);
    push_obs(48'd10,  4'd2,  1'b1, 8'd255, ppg_pkg::CMD_NONE);
    push_obs(48'd20,  4'd15, 1'b1, 8'd255, ppg_pkg::CMD_BRIGHT_UP);
    push_obs(48'd30,  4'd1,  1'b1, 8'd90,  ppg_pkg::CMD_PRIVACY_OFF);
    push_obs(48'd45,  4'd1,  1'b1, 8'd10,  ppg_pkg::CMD_NONE);
    push_obs(48'd50,  4'd1,  1'b0, 8'd10,  ppg_pkg::CMD_ACK);
    push_obs(48'd40,  4'd1,  1'b0, 8'd10,  ppg_pkg::CMD_PAUSE);
    push_obs(48'd70,  4'd1,  1'b1, 8'd10,  ppg_pkg::CMD_RESUME);
    push_obs(48'd75,  4'd1,  1'b1, 8'd10,  ppg_pkg::CMD_BRIGHT_DOWN);
    push_obs(48'd200, 4'd1,  1'b1, 8'd10,  ppg_pkg::CMD_NONE);
    push_obs(48'd230, 4'd1,  1'b1, 8'd10,  ppg_pkg::CMD_NONE);
    push_obs(48'd231, 4'd0,  1'b0, 8'd0,   ppg_pkg::CMD_NONE);
    push_obs(TS_TOP,  4'd0,  1'b1, 8'd0,   ppg_pkg::CMD_NONE);
    push_obs(48'd0,   4'd0,  1'b1, 8'd0,   ppg_pkg::CMD_PRIVACY_ON);
    push_obs(48'd100, 4'd0,  1'b1, 8'd0,   ppg_pkg::CMD_NONE);
    push_obs(48'd110, 4'd1,  1'b1, 8'd0,   ppg_pkg::CMD_ACK);
    push_obs(48'd120, 4'd0,  1'b1, 8'd0,   ppg_pkg::CMD_NONE);
    push_obs(48'd135, 4'd0,  1'b1, 8'd0,   ppg_pkg::CMD_NONE);
    push_obs(48'd150, 4'd0,  1'b1, 8'd0,   ppg_pkg::CMD_NONE);
    push_obs(48'd160, 4'd3,  1'b1, 8'd255, ppg_pkg::CMD_NONE);
    push_obs(48'd161, 4'd0,  1'b0, 8'd0,   ppg_pkg::CMD_ACK);
    push_obs(48'd175, 4'd5,  1'b1, 8'd70,  ppg_pkg::CMD_PRIVACY_OFF);
    push_obs(48'd190, 4'd1,  1'b1, 8'd69,  ppg_pkg::CMD_PAUSE);
    obs_clock = 48'd190;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence of the run
  // ---------------------------------------------------------------------------
  initial begin
    // Tracked state starts where the block's reset leaves it.
    lim_sit        = ppg_pkg::SIT_LIMIT_RST;
    lim_ack        = ppg_pkg::ACK_GRACE_RST;
    lim_break      = ppg_pkg::BREAK_CONFIRM_RST;
    lim_priv       = ppg_pkg::PRIV_LEAVE_RST;
    lim_hold       = ppg_pkg::POSTURE_HOLD_RST;
    lim_posture    = ppg_pkg::POSTURE_LIMIT_RST;
    lim_lock_unans = 1'b1;
    lim_lock_priv  = 1'b1;
    {g_started, g_present, g_posture_done, g_sit_done, g_wait_ack, g_locked} = '0;
    {g_paused, g_privacy, g_blurred, g_frozen, g_ack_restart} = '0;
    {g_present_at, g_absent_at, g_bad_at, g_ack_at, g_frozen_at} = '0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Short timers, so alerts and locks fire within a few dozen words.
    program_limits(32'd40, 32'd15, 32'd25, 32'd10, 32'd8, 8'd70, 1'b1, 1'b1);
    queue_directed();
    queue_random(130);
    drain();

    // Every limit at zero and both lock features off.
    program_limits('0, '0, '0, '0, '0, 8'd0, 1'b0, 1'b0);
    queue_random(70);
    drain();

    // Every limit at its maximum; only the far jumps of the clock reach them.
    program_limits('1, '1, '1, '1, '1, 8'hFF, 1'b1, 1'b1);
    queue_random(60);
    drain();

    // Random short settings with random lock enables.
    repeat (2) begin
      program_limits($urandom_range(0, 80), $urandom_range(0, 40), $urandom_range(0, 60),
                     $urandom_range(0, 30), $urandom_range(0, 20),
                     8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
      queue_random(85);
      drain();
    end

    // Give the block time to show any word it should not send.
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
